>>> rtl/rag_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the microprogram for the GCD reduction unit.
// No dependencies.
package rag_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int IN_W  = 16;
  localparam int MAG_W = 2 * OPERAND_WIDTH;
  localparam int NUM_W = 2 * OPERAND_WIDTH + 1;
  localparam int DEN_W = 2 * OPERAND_WIDTH;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int UPC_W = 5;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_LOAD   = 4'd1,
    OP_MUL1   = 4'd2,
    OP_MUL2   = 4'd3,
    OP_MUL3   = 4'd4,
    OP_DEN    = 4'd5,
    OP_GINIT  = 4'd6,
    OP_MODSET = 4'd7,
    OP_DSTEP  = 4'd8,
    OP_MODUPD = 4'd9,
    OP_NDSET  = 4'd10,
    OP_NUPD   = 4'd11,
    OP_DDSET  = 4'd12,
    OP_DUPD   = 4'd13,
    OP_SETERR = 4'd14,
    OP_EMIT   = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_START = 3'd2,
    C_GCD_END  = 3'd3,
    C_G_ZERO   = 3'd4,
    C_DIV_BUSY = 3'd5,
    C_OUT_FREE = 3'd6
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic gcd_end;
    logic g_zero;
    logic div_last;
  } dp_flags_t;

  typedef struct packed {
    logic      start;
    logic      out_free;
    dp_flags_t dp;
  } seq_cond_t;

  localparam logic [UPC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [UPC_W-1:0] S_MUL1    = 5'd1;
  localparam logic [UPC_W-1:0] S_MUL2    = 5'd2;
  localparam logic [UPC_W-1:0] S_MUL3    = 5'd3;
  localparam logic [UPC_W-1:0] S_DEN     = 5'd4;
  localparam logic [UPC_W-1:0] S_GINIT   = 5'd5;
  localparam logic [UPC_W-1:0] S_GTEST   = 5'd6;
  localparam logic [UPC_W-1:0] S_MODSET  = 5'd7;
  localparam logic [UPC_W-1:0] S_MODSTEP = 5'd8;
  localparam logic [UPC_W-1:0] S_MODUPD  = 5'd9;
  localparam logic [UPC_W-1:0] S_GDONE   = 5'd10;
  localparam logic [UPC_W-1:0] S_NDSET   = 5'd11;
  localparam logic [UPC_W-1:0] S_NDSTEP  = 5'd12;
  localparam logic [UPC_W-1:0] S_NUPD    = 5'd13;
  localparam logic [UPC_W-1:0] S_DDSET   = 5'd14;
  localparam logic [UPC_W-1:0] S_DDSTEP  = 5'd15;
  localparam logic [UPC_W-1:0] S_DUPD    = 5'd16;
  localparam logic [UPC_W-1:0] S_ZERO    = 5'd17;
  localparam logic [UPC_W-1:0] S_EMIT    = 5'd18;
  localparam logic [UPC_W-1:0] S_HOLD    = 5'd19;

  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    case (addr)
      S_IDLE:    w = '{op: OP_LOAD,   cond: C_NO_START, target: S_IDLE};
      S_MUL1:    w = '{op: OP_MUL1,   cond: C_NEVER,    target: S_IDLE};
      S_MUL2:    w = '{op: OP_MUL2,   cond: C_NEVER,    target: S_IDLE};
      S_MUL3:    w = '{op: OP_MUL3,   cond: C_NEVER,    target: S_IDLE};
      S_DEN:     w = '{op: OP_DEN,    cond: C_NEVER,    target: S_IDLE};
      S_GINIT:   w = '{op: OP_GINIT,  cond: C_NEVER,    target: S_IDLE};
      S_GTEST:   w = '{op: OP_NOP,    cond: C_GCD_END,  target: S_GDONE};
      S_MODSET:  w = '{op: OP_MODSET, cond: C_NEVER,    target: S_IDLE};
      S_MODSTEP: w = '{op: OP_DSTEP,  cond: C_DIV_BUSY, target: S_MODSTEP};
      S_MODUPD:  w = '{op: OP_MODUPD, cond: C_ALWAYS,   target: S_GTEST};
      S_GDONE:   w = '{op: OP_NOP,    cond: C_G_ZERO,   target: S_ZERO};
      S_NDSET:   w = '{op: OP_NDSET,  cond: C_NEVER,    target: S_IDLE};
      S_NDSTEP:  w = '{op: OP_DSTEP,  cond: C_DIV_BUSY, target: S_NDSTEP};
      S_NUPD:    w = '{op: OP_NUPD,   cond: C_NEVER,    target: S_IDLE};
      S_DDSET:   w = '{op: OP_DDSET,  cond: C_NEVER,    target: S_IDLE};
      S_DDSTEP:  w = '{op: OP_DSTEP,  cond: C_DIV_BUSY, target: S_DDSTEP};
      S_DUPD:    w = '{op: OP_DUPD,   cond: C_ALWAYS,   target: S_EMIT};
      S_ZERO:    w = '{op: OP_SETERR, cond: C_NEVER,    target: S_IDLE};
      S_EMIT:    w = '{op: OP_EMIT,   cond: C_OUT_FREE, target: S_IDLE};
      S_HOLD:    w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_EMIT};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/rag_seq.sv
`timescale 1ns / 1ps
// Microprogram sequencer: step counter, control ROM lookup, conditional jumps.
// Depends on rag_pkg.
module rag_seq import rag_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_cond_t cond_i,
  output op_e       op_o,
  output logic      idle_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            cw;
  logic             take;

  assign cw     = ucode_rom(upc_q);
  assign op_o   = cw.op;
  assign idle_o = (upc_q == S_IDLE);

  always_comb begin
    case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_START: take = !cond_i.start;
      C_GCD_END:  take = cond_i.dp.gcd_end;
      C_G_ZERO:   take = cond_i.dp.g_zero;
      C_DIV_BUSY: take = !cond_i.dp.div_last;
      C_OUT_FREE: take = cond_i.out_free;
      default:    take = 1'b0;
    endcase
    upc_d = take ? cw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/rag_dp.sv
`timescale 1ns / 1ps
// Datapath: operand registers, multiplier, sign-magnitude adder, GCD registers
// and a shared radix-2 divider. Depends on rag_pkg.
module rag_dp import rag_pkg::*; (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  op_e                     op_i,
  input  logic [1:0]              action_i,
  input  logic signed [IN_W-1:0]  a_num_i,
  input  logic signed [IN_W-1:0]  a_den_i,
  input  logic signed [IN_W-1:0]  b_num_i,
  input  logic signed [IN_W-1:0]  b_den_i,
  output dp_flags_t               flags_o,
  output logic signed [NUM_W-1:0] res_num_o,
  output logic signed [DEN_W-1:0] res_den_o,
  output logic                    status_o
);

  typedef struct packed {
    logic                     neg;
    logic [OPERAND_WIDTH-1:0] mag;
  } sm_op_t;

  function automatic sm_op_t take_operand(input logic [IN_W-1:0] raw);
    sm_op_t r;
    logic [OPERAND_WIDTH-1:0] v;
    v     = raw[OPERAND_WIDTH-1:0];
    r.neg = v[OPERAND_WIDTH-1];
    r.mag = r.neg ? (~v + OPERAND_WIDTH'(1)) : v;
    return r;
  endfunction

  act_e             act_q;
  sm_op_t           an_q, ad_q, bn_q, bd_q;
  logic [MAG_W-1:0] prod_q;
  logic             prod_neg_q;
  logic [MAG_W-1:0] p_q, q_q;
  logic             pn_q, qn_q;
  logic [MAG_W-1:0] ga_q, gb_q;
  logic             sel_q;
  logic [MAG_W-1:0] quo_q, rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             err_q;

  sm_op_t           mul_x, mul_y;
  logic [MAG_W-1:0] prod_full;
  logic             arith;
  logic             add_neg2, same_sign, p_ge;
  logic [MAG_W-1:0] sum_mag;
  logic             sum_neg;
  logic [MAG_W:0]   trial, diff;
  logic             fits;
  logic [MAG_W-1:0] rem_d, quo_d, g_val;
  logic             ga_gt;

  assign arith = (act_q == ACT_ADD) || (act_q == ACT_SUB);

  always_comb begin
    case (op_i)
      OP_MUL1: begin
        mul_x = an_q;
        mul_y = (act_q == ACT_MUL) ? bn_q : bd_q;
      end
      OP_MUL2: begin
        mul_x = ad_q;
        mul_y = (act_q == ACT_MUL) ? bd_q : bn_q;
      end
      default: begin
        mul_x = ad_q;
        mul_y = bd_q;
      end
    endcase
  end

  assign prod_full = MAG_W'(mul_x.mag) * MAG_W'(mul_y.mag);

  assign add_neg2  = prod_neg_q ^ (act_q == ACT_SUB);
  assign same_sign = (pn_q == add_neg2);
  assign p_ge      = (p_q >= prod_q);
  assign sum_mag   = same_sign ? (p_q + prod_q) : (p_ge ? (p_q - prod_q) : (prod_q - p_q));
  assign sum_neg   = (same_sign || p_ge) ? pn_q : add_neg2;

  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = !diff[MAG_W];
  assign rem_d = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
  assign quo_d = {quo_q[MAG_W-2:0], fits};

  assign g_val = ga_q | gb_q;
  assign ga_gt = (ga_q > gb_q);

  assign flags_o.gcd_end  = (ga_q == '0) || (gb_q == '0);
  assign flags_o.g_zero   = (g_val == '0);
  assign flags_o.div_last = (cnt_q == CNT_W'(MAG_W - 1));

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        if (load_i) begin
          act_q <= act_e'(action_i);
          an_q  <= take_operand(a_num_i);
          ad_q  <= take_operand(a_den_i);
          bn_q  <= take_operand(b_num_i);
          bd_q  <= take_operand(b_den_i);
          err_q <= 1'b0;
        end
      end
      OP_MUL1: begin
        prod_q     <= prod_full;
        prod_neg_q <= mul_x.neg ^ mul_y.neg;
      end
      OP_MUL2: begin
        p_q        <= prod_q;
        pn_q       <= prod_neg_q;
        prod_q     <= prod_full;
        prod_neg_q <= mul_x.neg ^ mul_y.neg;
      end
      OP_MUL3: begin
        if (arith) begin
          p_q  <= sum_mag;
          pn_q <= sum_neg;
        end else begin
          q_q  <= prod_q;
          qn_q <= prod_neg_q;
        end
        prod_q     <= prod_full;
        prod_neg_q <= mul_x.neg ^ mul_y.neg;
      end
      OP_DEN: begin
        if (arith) begin
          q_q  <= prod_q;
          qn_q <= prod_neg_q;
        end
      end
      OP_GINIT: begin
        ga_q <= p_q;
        gb_q <= q_q;
      end
      OP_MODSET: begin
        sel_q <= ga_gt;
        quo_q <= ga_gt ? ga_q : gb_q;
        dvs_q <= ga_gt ? gb_q : ga_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_DSTEP: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_MODUPD: begin
        if (sel_q) begin
          ga_q <= rem_q;
        end else begin
          gb_q <= rem_q;
        end
      end
      OP_NDSET: begin
        quo_q <= p_q;
        dvs_q <= g_val;
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_NUPD: begin
        p_q <= quo_q;
      end
      OP_DDSET: begin
        quo_q <= q_q;
        dvs_q <= g_val;
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_DUPD: begin
        q_q <= quo_q;
      end
      OP_SETERR: begin
        err_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (err_q) begin
      res_num_o = '0;
      res_den_o = '0;
    end else begin
      res_num_o = pn_q ? -{1'b0, p_q} : {1'b0, p_q};
      res_den_o = qn_q ? -q_q : q_q;
    end
  end

  assign status_o = err_q;

endmodule

>>> rtl/rational_arith_gcd_reduce_unit.sv
`timescale 1ns / 1ps
// Top level of the rational add/sub/mul/div unit with GCD reduction.
// Depends on rag_pkg, rag_seq and rag_dp.
//
// Input channel (in_valid_i / in_stall_o): one transfer carries an action and
// two signed fractions. Output channel (out_valid_o / out_stall_i): one
// transfer carries the reduced numerator, denominator and a status bit that is
// set when both unreduced parts were zero (result 0/0).
// One item is in flight at a time; in_stall_o is low only while the sequencer
// sits in its idle step. A microprogram drives three multiplies, an add, a
// Euclidean GCD by repeated modulo and two exact divisions, all on one
// radix-2 divider that retires one quotient bit per cycle.
// An item whose parts are both zero skips the two exact divisions.
// The result sits in an output register; the next item is accepted and
// processed while it waits. If the receiver still stalls when the next result
// is ready, the sequencer waits at its emit step until the register frees.
// Reset returns the sequencer to idle and empties the output register.
module rational_arith_gcd_reduce_unit import rag_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic signed [IN_W-1:0]  a_num_i,
  input  logic signed [IN_W-1:0]  a_den_i,
  input  logic signed [IN_W-1:0]  b_num_i,
  input  logic signed [IN_W-1:0]  b_den_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [NUM_W-1:0] res_num_o,
  output logic signed [DEN_W-1:0] res_den_o,
  output logic                    status_o
);

  op_e                     op;
  logic                    idle;
  logic                    load;
  logic                    out_free;
  logic                    emit;
  dp_flags_t               flags;
  seq_cond_t               cond;
  logic signed [NUM_W-1:0] dp_num;
  logic signed [DEN_W-1:0] dp_den;
  logic                    dp_status;

  logic                    out_valid_q;
  logic signed [NUM_W-1:0] res_num_q;
  logic signed [DEN_W-1:0] res_den_q;
  logic                    status_q;

  assign load     = in_valid_i && idle;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (op == OP_EMIT) && out_free;

  assign cond.start    = in_valid_i;
  assign cond.out_free = out_free;
  assign cond.dp       = flags;

  rag_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .op_o   (op),
    .idle_o (idle)
  );

  rag_dp u_dp (
    .clk_i     (clk_i),
    .load_i    (load),
    .op_i      (op),
    .action_i  (action_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .flags_o   (flags),
    .res_num_o (dp_num),
    .res_den_o (dp_den),
    .status_o  (dp_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_num_q <= dp_num;
      res_den_q <= dp_den;
      status_q  <= dp_status;
    end
  end

  assign in_stall_o  = !idle;
  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign status_o    = status_q;

endmodule

>>> tb/tb_rational_arith_gcd_reduce_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for rational_arith_gcd_reduce_unit: a directed table and random
// fraction pairs, checked against table results or a sign-magnitude Euclidean GCD predictor.
// Depends on rag_pkg and the unit's RTL.
module tb_rational_arith_gcd_reduce_unit;
  import rag_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int RANDOM_ITEMS    = 1000;
  localparam logic signed [IN_W-1:0] OPD_MIN = 16'sh8000;
  localparam logic signed [IN_W-1:0] OPD_MAX = 16'sh7fff;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    status;
  } frac_res_t;

  typedef struct packed {
    bit              neg;
    longint unsigned mag;
  } sgn_mag_t;

  typedef struct {
    act_e                   act;
    logic signed [IN_W-1:0] an;
    logic signed [IN_W-1:0] ad;
    logic signed [IN_W-1:0] bn;
    logic signed [IN_W-1:0] bd;
    bit                     typed;
    frac_res_t              res;
  } stim_row_t;

  localparam frac_res_t NO_RES = '0;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              action_i;
  logic signed [IN_W-1:0]  a_num_i;
  logic signed [IN_W-1:0]  a_den_i;
  logic signed [IN_W-1:0]  b_num_i;
  logic signed [IN_W-1:0]  b_den_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [NUM_W-1:0] res_num_o;
  logic signed [DEN_W-1:0] res_den_o;
  logic                    status_o;

  frac_res_t pending_fracs[$];
  stim_row_t dir_rows[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        in_burst = 1'b0;
  bit        stall_quiet = 1'b0;

  rational_arith_gcd_reduce_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .status_o   (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic sgn_mag_t to_sgn_mag(input logic signed [IN_W-1:0] raw);
    logic signed [OPERAND_WIDTH-1:0] low;
    longint                          wide;
    sgn_mag_t                        r;
    low   = raw[OPERAND_WIDTH-1:0];
    wide  = longint'(low);
    r.neg = (wide < 0);
    r.mag = r.neg ? -wide : wide;
    return r;
  endfunction

  function automatic sgn_mag_t mul_sm(input sgn_mag_t x, input sgn_mag_t y);
    sgn_mag_t r;
    r.neg = x.neg ^ y.neg;
    r.mag = x.mag * y.mag;
    return r;
  endfunction

  function automatic sgn_mag_t add_sm(input sgn_mag_t x, input sgn_mag_t y);
    sgn_mag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  function automatic frac_res_t reduce_frac(input act_e act,
                                            input logic signed [IN_W-1:0] a_n,
                                            input logic signed [IN_W-1:0] a_d,
                                            input logic signed [IN_W-1:0] b_n,
                                            input logic signed [IN_W-1:0] b_d);
    sgn_mag_t        an, ad, bn, bd, num, den, t;
    longint unsigned p, q, g, nv, dv;
    frac_res_t       r;
    an = to_sgn_mag(a_n);
    ad = to_sgn_mag(a_d);
    bn = to_sgn_mag(b_n);
    bd = to_sgn_mag(b_d);
    case (act)
      ACT_ADD: begin
        num = add_sm(mul_sm(an, bd), mul_sm(bn, ad));
        den = mul_sm(ad, bd);
      end
      ACT_SUB: begin
        t     = mul_sm(bn, ad);
        t.neg = !t.neg;
        num   = add_sm(mul_sm(an, bd), t);
        den   = mul_sm(ad, bd);
      end
      ACT_MUL: begin
        num = mul_sm(an, bn);
        den = mul_sm(ad, bd);
      end
      default: begin
        num = mul_sm(an, bd);
        den = mul_sm(ad, bn);
      end
    endcase
    p = num.mag;
    q = den.mag;
    while (p != 0 && q != 0) begin
      if (p > q) p = p % q;
      else q = q % p;
    end
    g = p + q;
    if (g == 0) begin
      r.num    = '0;
      r.den    = '0;
      r.status = 1'b1;
      return r;
    end
    nv       = num.mag / g;
    dv       = den.mag / g;
    r.num    = NUM_W'(num.neg ? -nv : nv);
    r.den    = DEN_W'(den.neg ? -dv : dv);
    r.status = 1'b0;
    return r;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic signed [IN_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return OPD_MIN;
          1: return OPD_MAX;
          2: return 16'sd1;
          3: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      1, 2, 3: return IN_W'($urandom_range(0, 40) - 20);
      4: return 16'sd0;
      default: return IN_W'($urandom);
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_frac(input act_e act,
                           input logic signed [IN_W-1:0] an,
                           input logic signed [IN_W-1:0] ad,
                           input logic signed [IN_W-1:0] bn,
                           input logic signed [IN_W-1:0] bd,
                           input bit typed, input frac_res_t typed_res);
    int gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i   <= act;
    a_num_i    <= an;
    a_den_i    <= ad;
    b_num_i    <= bn;
    b_den_i    <= bd;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_fracs.push_back(typed ? typed_res : reduce_frac(act, an, ad, bn, bd));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (!stall_quiet && !out_stall_i && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    frac_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fracs.size() == 0) begin
        $error("unexpected result transfer: %0d / %0d status %0d",
               res_num_o, res_den_o, status_o);
        mismatch_count++;
      end else begin
        want = pending_fracs.pop_front();
        if (res_num_o !== want.num) begin
          $error("res_num: expected %0d, got %0d", want.num, res_num_o);
          mismatch_count++;
        end
        if (res_den_o !== want.den) begin
          $error("res_den: expected %0d, got %0d", want.den, res_den_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = ACT_ADD;
    a_num_i    = '0;
    a_den_i    = '0;
    b_num_i    = '0;
    b_den_i    = '0;

    dir_rows.push_back('{ACT_ADD, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1,
                         '{33'sd0, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
                         '{33'sd0, 32'sd0, 1'b1}});
    dir_rows.push_back('{ACT_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
                         '{33'sd0, 32'sd0, 1'b1}});
    dir_rows.push_back('{ACT_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
                         '{33'sd0, 32'sd0, 1'b1}});
    dir_rows.push_back('{ACT_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
                         '{33'sd0, 32'sd0, 1'b1}});
    dir_rows.push_back('{ACT_DIV, 16'sd1, 16'sd1, 16'sd0, 16'sd1, 1'b1,
                         '{33'sd1, 32'sd0, 1'b0}});
    dir_rows.push_back('{ACT_MUL, OPD_MIN, OPD_MIN, OPD_MIN, OPD_MIN, 1'b1,
                         '{33'sd1, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_MUL, OPD_MAX, 16'sd1, OPD_MAX, 16'sd1, 1'b1,
                         '{33'sd1073676289, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1,
                         '{33'sd0, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_ADD, OPD_MIN, 16'sd1, OPD_MIN, 16'sd1, 1'b1,
                         '{-33'sd65536, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_ADD, OPD_MIN, OPD_MIN, OPD_MIN, OPD_MIN, 1'b1,
                         '{33'sd2, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_ADD, OPD_MAX, OPD_MAX, OPD_MAX, OPD_MAX, 1'b1,
                         '{33'sd2, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_SUB, 16'sd0, -16'sd1, 16'sd0, 16'sd1, 1'b1,
                         '{33'sd0, -32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd0, 1'b1,
                         '{33'sd0, 32'sd0, 1'b1}});
    dir_rows.push_back('{ACT_MUL, -16'sd3, 16'sd1, 16'sd5, 16'sd0, 1'b1,
                         '{-33'sd1, 32'sd0, 1'b0}});
    dir_rows.push_back('{ACT_MUL, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1,
                         '{33'sd1, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_SUB, OPD_MIN, 16'sd1, OPD_MAX, 16'sd1, 1'b1,
                         '{-33'sd65535, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_DIV, 16'sd5, 16'sd7, 16'sd5, 16'sd7, 1'b1,
                         '{33'sd1, 32'sd1, 1'b0}});
    dir_rows.push_back('{ACT_DIV, OPD_MIN, OPD_MAX, OPD_MAX, OPD_MIN, 1'b0, NO_RES});
    dir_rows.push_back('{ACT_SUB, OPD_MAX, OPD_MIN, OPD_MIN, OPD_MAX, 1'b0, NO_RES});
    dir_rows.push_back('{ACT_ADD, 16'sd1, -16'sd2, 16'sd1, 16'sd3, 1'b0, NO_RES});
    dir_rows.push_back('{ACT_DIV, 16'sd6, 16'sd4, -16'sd9, 16'sd2, 1'b0, NO_RES});
    dir_rows.push_back('{ACT_MUL, 16'sd12, -16'sd18, -16'sd27, 16'sd8, 1'b0, NO_RES});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_frac(row.act, row.an, row.ad, row.bn, row.bd, row.typed, row.res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        in_burst    = ($urandom_range(0, 3) == 0);
        stall_quiet = ($urandom_range(0, 3) == 0);
      end
      send_frac(act_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand(), 1'b0, NO_RES);
    end
    in_valid_i <= 1'b0;

    while (pending_fracs.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
